// ----- rtl/septet_packer_core_assert.svh -----
// Assertion macros for the septet packer checker.
`ifndef SEPTET_PACKER_CORE_ASSERT_SVH
`define SEPTET_PACKER_CORE_ASSERT_SVH

// Checked only while out of reset.
`define SPK_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("septet packer check failed");

// Checked at every edge, reset included.
`define SPK_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("septet packer check failed");

`endif

// ----- rtl/spk_pkg.sv -----
// Types and constants of the septet packer.
package spk_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LIMIT = 1'd1;

  localparam logic [2:0] START_OFFSET_RST = 3'd0;
  localparam logic [7:0] BUFFER_LIMIT_RST = 8'd140;

  typedef struct packed {
    logic [6:0] septet;
    logic       last_char;
  } spk_in_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       byte_valid;
    logic       message_end;
    logic [7:0] packed_length;
    logic       overflow;
  } spk_out_t;

  typedef struct packed {
    logic [2:0] start_offset;
    logic [7:0] buffer_limit;
  } spk_cfg_t;

  // One queued command: one result, or two when a last character completes a
  // byte and still leaves bits to flush.
  typedef struct packed {
    logic     two;
    spk_out_t res0;
    spk_out_t res1;
  } spk_entry_t;

endpackage

// ----- rtl/septet_packer_core.sv -----
// Top level of the septet packer: config registers, front end, queue, output stage.
// Packs 7-bit characters LSB-first into bytes from the configured start offset,
// with zero fill bits below it. One character is taken per cycle while in_ready is
// high; its results enter the command queue in the cycle after and reach out_* at
// its head. A last character that completes a byte and leaves a partial one gives
// two results, played out as two transfers. The queue (QUEUE_DEPTH commands)
// decouples the two sides; in_ready drops only while it is full. start_offset is
// sampled at a message's first character, buffer_limit at each until overrun.
module septet_packer_core
  import spk_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  spk_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output spk_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  spk_cfg_t   cfg_r;
  spk_entry_t push_entry;
  spk_entry_t head_entry;
  logic       take;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_offset <= START_OFFSET_RST;
      cfg_r.buffer_limit <= BUFFER_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_OFFSET: cfg_r.start_offset <= cfg_wdata[2:0];
        CFG_BUFFER_LIMIT: cfg_r.buffer_limit <= cfg_wdata[7:0];
      endcase
    end
  end

  assign in_ready = !q_full;
  assign take     = in_valid & in_ready;

  spk_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_data (in_data),
    .cfg     (cfg_r),
    .push    (push),
    .entry   (push_entry)
  );

  spk_queue #(
    .WIDTH ($bits(spk_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wdata     (push_entry),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .rdata     (head_entry)
  );

  spk_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_not_empty),
    .head       (head_entry),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .pop        (pop)
  );

endmodule

// ----- rtl/spk_front.sv -----
// Front end: packs each accepted septet and queues the results it causes.
module spk_front
  import spk_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  spk_in_t    in_data,
  input  spk_cfg_t   cfg,
  output logic       push,
  output spk_entry_t entry
);

  logic       active_r, active_nxt;
  logic       ovf_r, ovf_nxt;
  logic [2:0] shift_r, shift_nxt;
  logic [7:0] part_r, part_nxt;
  logic [7:0] bd_r, bd_nxt;

  logic [2:0]  cur_shift;
  logic [7:0]  cur_part;
  logic [7:0]  cur_bd;
  logic        cur_ovf;
  logic [14:0] acc;
  logic [8:0]  bd_inc;
  logic [7:0]  bd_p1;
  logic [7:0]  bd_p2;
  logic        over;
  logic        last;
  logic        push_c;

  function automatic spk_out_t mk_res(logic [7:0] pbyte, logic bval, logic mend,
                                      logic [7:0] plen, logic ovfl);
    spk_out_t r;
    r.packed_byte   = pbyte;
    r.byte_valid    = bval;
    r.message_end   = mend;
    r.packed_length = plen;
    r.overflow      = ovfl;
    return r;
  endfunction

  // A new message starts from the configured offset.
  assign cur_shift = active_r ? shift_r : cfg.start_offset;
  assign cur_part  = active_r ? part_r  : 8'd0;
  assign cur_bd    = active_r ? bd_r    : 8'd0;
  assign cur_ovf   = active_r & ovf_r;
  assign last      = in_data.last_char;

  assign acc    = {7'd0, cur_part} | ({8'd0, in_data.septet} << cur_shift);
  assign bd_inc = {1'b0, cur_bd} + 9'd1;
  assign bd_p1  = bd_inc[7:0];
  assign bd_p2  = cur_bd + 8'd2;
  assign over   = (cur_bd >= cfg.buffer_limit) ||
                  ((cur_shift > 3'd1) && (bd_inc >= {1'b0, cfg.buffer_limit}));

  always_comb begin
    active_nxt = 1'b1;
    ovf_nxt    = cur_ovf;
    shift_nxt  = cur_shift;
    part_nxt   = cur_part;
    bd_nxt     = cur_bd;
    push_c     = 1'b0;
    entry.two  = 1'b0;
    entry.res0 = mk_res(8'd0, 1'b0, 1'b0, 8'd0, 1'b0);
    entry.res1 = mk_res(8'd0, 1'b0, 1'b0, 8'd0, 1'b0);
    if (cur_ovf) begin
      if (last) begin
        push_c     = 1'b1;
        entry.res0 = mk_res(8'd0, 1'b0, 1'b1, cur_bd, 1'b1);
        active_nxt = 1'b0;
      end
    end else if (over) begin
      push_c     = 1'b1;
      entry.res0 = mk_res(8'd0, 1'b0, last, last ? cur_bd : 8'd0, 1'b1);
      ovf_nxt    = 1'b1;
      part_nxt   = 8'd0;
      active_nxt = !last;
    end else if (cur_shift != 3'd0) begin
      // byte completes; the carry keeps the septet's upper bits
      bd_nxt    = bd_p1;
      part_nxt  = {1'b0, acc[14:8]};
      shift_nxt = cur_shift - 3'd1;
      push_c    = 1'b1;
      if (last && cur_shift == 3'd1) begin
        entry.res0 = mk_res(acc[7:0], 1'b1, 1'b1, bd_p1, 1'b0);
        active_nxt = 1'b0;
      end else begin
        entry.res0 = mk_res(acc[7:0], 1'b1, 1'b0, 8'd0, 1'b0);
        if (last) begin
          entry.two  = 1'b1;
          entry.res1 = mk_res({1'b0, acc[14:8]}, 1'b1, 1'b1, bd_p2, 1'b0);
          active_nxt = 1'b0;
        end
      end
    end else begin
      part_nxt  = acc[7:0];
      shift_nxt = 3'd7;
      if (last) begin
        push_c     = 1'b1;
        entry.res0 = mk_res(acc[7:0], 1'b1, 1'b1, bd_p1, 1'b0);
        active_nxt = 1'b0;
      end
    end
  end

  assign push = take & push_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ovf_r    <= 1'b0;
      shift_r  <= 3'd0;
      part_r   <= 8'd0;
      bd_r     <= 8'd0;
    end else if (take) begin
      active_r <= active_nxt;
      ovf_r    <= ovf_nxt;
      shift_r  <= shift_nxt;
      part_r   <= part_nxt;
      bd_r     <= bd_nxt;
    end
  end

endmodule

// ----- rtl/spk_queue.sv -----
// Short command queue between the packing front end and the output stage.
module spk_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_nxt;
      if (pop)  rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

// ----- rtl/spk_back.sv -----
// Output stage: plays each queued command out as one or two result transfers.
module spk_back
  import spk_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  spk_entry_t head,
  input  logic       out_ready,
  output logic       out_valid,
  output spk_out_t   out_data,
  output logic       pop
);

  logic sel_r, sel_nxt;
  logic xfer;

  assign out_valid = head_valid;
  assign out_data  = sel_r ? head.res1 : head.res0;
  assign xfer      = out_valid & out_ready;
  assign pop       = xfer & (!head.two | sel_r);
  assign sel_nxt   = xfer ? !pop : sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

endmodule

// ----- rtl/spk_checker.sv -----
// Port-level checks on the septet packer, bound to the top level.
`include "septet_packer_core_assert.svh"

module spk_checker
  import spk_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input spk_out_t out_data
);

  `SPK_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data))
  `SPK_ASSERT(a_nodata_is_ovf, clk, rst_n, out_valid && !out_data.byte_valid |-> out_data.overflow)
  `SPK_ASSERT(a_data_no_ovf, clk, rst_n, out_valid && out_data.byte_valid |-> !out_data.overflow)
  `SPK_ASSERT(a_len_at_end, clk, rst_n, out_valid && !out_data.message_end |-> out_data.packed_length == 8'd0)
  `SPK_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid)

endmodule

bind septet_packer_core spk_checker u_spk_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- test/septet_packer_core_tb.sv -----
// Self-checking testbench for septet_packer_core: random and directed characters, stream checks.
`timescale 1ns / 100ps

module septet_packer_core_tb;
  import spk_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  spk_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  spk_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_START_OFFSET;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  septet_packer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Characters waiting to be sent and packer output still owed.
  spk_in_t  char_queue[$];
  spk_out_t byte_queue[$];

  // Register shadow and packing state of the open message.
  logic [2:0] cfg_offset = START_OFFSET_RST;
  logic [7:0] cfg_limit  = BUFFER_LIMIT_RST;
  logic [2:0] bit_pos    = '0;
  logic [7:0] carry      = '0;
  logic [7:0] bytes_out  = '0;
  logic       overran    = 1'b0;
  logic       msg_open   = 1'b0;

  bit failed   = 1'b0;
  bit steady   = 1'b0;
  bit in_taken = 1'b0;
  int in_gap   = 0;
  int out_gap  = 0;

  task automatic expect_result(input logic [7:0] pbyte, input logic bvalid, input logic mend,
                               input logic [7:0] plen, input logic ovf);
    spk_out_t r;
    r.packed_byte   = pbyte;
    r.byte_valid    = bvalid;
    r.message_end   = mend;
    r.packed_length = plen;
    r.overflow      = ovf;
    byte_queue.push_back(r);
  endtask

  task automatic pack_char(input spk_in_t c);
    logic [14:0] acc;
    int          nxt;
    logic        done_now;
    done_now = 1'b0;
    if (!msg_open) begin
      bit_pos   = cfg_offset;
      carry     = '0;
      bytes_out = '0;
      overran   = 1'b0;
      msg_open  = 1'b1;
    end
    if (overran) begin
      // rest of an overrun message is dropped; only its end reports
      if (c.last_char) begin
        expect_result(8'd0, 1'b0, 1'b1, bytes_out, 1'b1);
        msg_open = 1'b0;
      end
    end else if (bytes_out >= cfg_limit ||
                 (bit_pos > 3'd1 && int'(bytes_out) + 1 >= int'(cfg_limit))) begin
      overran = 1'b1;
      carry   = '0;
      expect_result(8'd0, 1'b0, c.last_char, c.last_char ? bytes_out : 8'd0, 1'b1);
      if (c.last_char) msg_open = 1'b0;
    end else begin
      acc = 15'(carry) | (15'(c.septet) << bit_pos);
      nxt = int'(bit_pos) + 7;
      if (nxt >= 8) begin
        bytes_out = bytes_out + 8'd1;
        carry     = 8'(acc >> 8);
        bit_pos   = 3'(nxt);
        // byte filled exactly by the last character: no flush needed
        done_now  = c.last_char && bit_pos == 3'd0;
        expect_result(acc[7:0], 1'b1, done_now, done_now ? bytes_out : 8'd0, 1'b0);
      end else begin
        carry   = acc[7:0];
        bit_pos = 3'(nxt);
      end
      if (c.last_char && !done_now)
        expect_result(carry, 1'b1, 1'b1, bytes_out + 8'd1, 1'b0);
      if (c.last_char) msg_open = 1'b0;
    end
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endfunction

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    spk_out_t want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        pack_char(in_data);
      end
      if (out_valid && out_ready) begin
        if (byte_queue.size() == 0) begin
          $error("output transfer with nothing expected: byte %0d", out_data.packed_byte);
          failed = 1'b1;
        end else begin
          want = byte_queue.pop_front();
          check_field("packed_byte", want.packed_byte, out_data.packed_byte);
          check_field("byte_valid", 8'(want.byte_valid), 8'(out_data.byte_valid));
          check_field("message_end", 8'(want.message_end), 8'(out_data.message_end));
          check_field("packed_length", want.packed_length, out_data.packed_length);
          check_field("overflow", 8'(want.overflow), 8'(out_data.overflow));
        end
      end
    end
  end

  // Input driver.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold until transfer
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap = in_gap - 1;
    end else if (char_queue.size() != 0) begin
      in_valid <= 1'b1;
      in_data  <= char_queue.pop_front();
      if (!steady && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 15);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Output backpressure.
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_ready <= 1'b0;
      out_gap = out_gap - 1;
    end else begin
      out_ready <= 1'b1;
      if (!steady && $urandom_range(0, 11) == 0) out_gap = $urandom_range(1, 15);
    end
  end

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_START_OFFSET) cfg_offset = val[2:0];
    else cfg_limit = val;
  endtask

  task automatic set_format(input int off, input int lim);
    write_cfg(CFG_START_OFFSET, 8'(off));
    write_cfg(CFG_BUFFER_LIMIT, 8'(lim));
  endtask

  task automatic push_char(input int s, input bit l);
    spk_in_t c;
    c.septet    = 7'(s);
    c.last_char = l;
    char_queue.push_back(c);
  endtask

  // Block is idle once everything is sent and owed output has come back.
  task automatic settle();
    while (char_queue.size() != 0 || in_valid || byte_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic int pick_septet();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 127;
      default: return $urandom_range(0, 127);
    endcase
  endfunction

  initial begin
    int offs[10];
    int lims[10];
    int sent;
    int len;
    int kind;
    offs = '{0, 7, 3, 5, 2, 6, 4, 1, 7, 2};
    lims = '{140, 255, 5, 1, 20, 3, 2, 255, 8, 30};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset format, single-character message flushed
    push_char(127, 1'b1);
    push_char(0, 1'b0); push_char(127, 1'b0); push_char(85, 1'b1);
    settle();
    // offset 1: one character fills the first byte exactly
    set_format(1, 140);
    push_char(127, 1'b1);
    settle();
    // offset 7, limit 1: overrun on first character, with and without last
    set_format(7, 1);
    push_char(127, 1'b1);
    push_char(0, 1'b0); push_char(127, 1'b1);
    settle();
    // overrun mid-message, silent characters, then the end report
    set_format(0, 1);
    push_char(127, 1'b0); push_char(127, 1'b0); push_char(1, 1'b0); push_char(127, 1'b1);
    settle();
    // zero limit overruns everything
    set_format(0, 0);
    push_char(42, 1'b1);
    settle();
    set_format(7, 255);
    push_char(127, 1'b0); push_char(0, 1'b0); push_char(127, 1'b1);
    settle();

    // long messages overshoot the per-phase count, so the target is kept low
    for (int ph = 0; ph < 10; ph++) begin
      set_format(offs[ph], lims[ph]);
      if (ph == 9) steady = 1'b1;
      sent = 0;
      while (sent < 60) begin
        kind = $urandom_range(0, 9);
        if (kind == 9) begin
          // noise: random message boundaries
          len = $urandom_range(1, 10);
          for (int i = 0; i < len; i++)
            push_char(pick_septet(), (i == len - 1) ? 1'b1 : 1'($urandom_range(0, 1)));
        end else begin
          if (kind <= 5) len = $urandom_range(1, 12);
          else if (kind <= 7) len = $urandom_range(13, 40);
          else len = (8 * lims[ph]) / 7 + $urandom_range(0, 4);
          for (int i = 0; i < len; i++)
            push_char(pick_septet(), i == len - 1);
        end
        sent += len;
      end
      settle();
    end

    if (!failed)
      $display("septet_packer_core_tb passed");
    else
      $display("septet_packer_core_tb failed");
    $finish;
  end

  initial begin
    #5000000;
    $display("septet_packer_core_tb failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/spk_pkg.sv
rtl/spk_front.sv
rtl/spk_queue.sv
rtl/spk_back.sv
rtl/septet_packer_core.sv
rtl/spk_checker.sv
test/septet_packer_core_tb.sv
